[src/lps_pkg.sv]
// Shared types and constants for the 3x3 Laplacian sharpening block.
package lps_pkg;

   localparam int KS     = 3;            // window side
   localparam int NB_N   = KS * KS - 1;  // neighbours around the centre
   localparam int PIX_W  = 8;
   localparam int VAL_W  = 18;
   localparam int GAIN_W = 8;
   localparam int IW_W   = 11;
   localparam int IH_W   = 12;
   localparam int ROW_W  = 13;           // input row runs up to height + 1
   localparam int TOT_W  = IW_W + IH_W;
   localparam int COEF_W = 9;
   localparam int PROD_W = PIX_W + COEF_W;
   localparam int NSUM_W = 11;
   localparam int IH_MAX = 4095;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_TYPE = 2'd0,
      CSR_GAIN        = 2'd1,
      CSR_WIDTH       = 2'd2,
      CSR_HEIGHT      = 2'd3
   } lps_csr_type;

   localparam logic FT_FOUR  = 1'b0;
   localparam logic FT_EIGHT = 1'b1;

   localparam logic [COEF_W-1:0] CTR_FOUR  = 9'd64;   // 4.0 in Q5.4
   localparam logic [COEF_W-1:0] CTR_EIGHT = 9'd128;  // 8.0 in Q5.4

   localparam logic [IW_W-1:0]   W_MIN      = 11'd3;
   localparam logic              RST_TYPE   = FT_FOUR;
   localparam logic [GAIN_W-1:0] RST_GAIN   = 8'd16;
   localparam logic [IW_W-1:0]   RST_WIDTH  = 11'd640;
   localparam logic [IH_W-1:0]   RST_HEIGHT = 12'd480;
   localparam logic [ROW_W-1:0]  ROW_SAT    = '1;

   // one window column: [0] oldest row, [2] current row
   typedef logic [KS-1:0][PIX_W-1:0] lps_col_type;

   // masked window handed to the arithmetic stage
   typedef struct packed {
      logic [NB_N-1:0][PIX_W-1:0] nb;
      logic [PIX_W-1:0]           ctr;
      logic [COEF_W-1:0]          coef;
      logic                       last;
   } lps_win_type;

endpackage

[src/lps_if.sv]
// Valid/ready channel interfaces for pixel items and result items.
interface lps_req_if;
   import lps_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   logic             flush;
   modport source (output valid, pixel, flush, input ready);
   modport sink (input valid, pixel, flush, output ready);
endinterface

interface lps_rsp_if;
   import lps_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] value;
   logic                    last;
   modport source (output valid, value, last, input ready);
   modport sink (input valid, value, last, output ready);
endinterface

[src/lps_ram.sv]
// Generic single write, single read RAM with registered read data.
module lps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[src/lps_cell.sv]
// Window cell: holds one pixel column and takes its neighbour's on a shift.
module lps_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  logic                clear,
   input  lps_pkg::lps_col_type nbr_col,
   output lps_pkg::lps_col_type own_col
);
   import lps_pkg::*;

   lps_col_type data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (clear) begin
         data_in = '0;
      end else if (shift) begin
         data_in = nbr_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign own_col = data_ff;
endmodule

[src/lps_div.sv]
// Restoring divider, one quotient bit per cycle.
module lps_div #(
   parameter int NUM_W = 22,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quotient,
   output logic [DEN_W-1:0] remainder
);
   localparam int STEP_W = $clog2(NUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    trial, diff;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(NUM_W);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], ge};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

`ifndef ASSERT_OFF
   a_step_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |-> step_ff != '0)
      else $error("divider busy with no steps left");
`endif
endmodule

[src/lps_kernel.sv]
// Kernel arithmetic stage and output register.
module lps_kernel (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  lps_pkg::lps_win_type win,
   output logic                 take,
   lps_rsp_if.source            rsp_bus
);
   import lps_pkg::*;

   logic                    s1_v_ff, s1_v_in;
   lps_win_type             s1_ff;
   logic                    out_v_ff, out_v_in;
   logic signed [VAL_W-1:0] out_value_ff;
   logic                    out_last_ff;
   logic                    out_free;
   logic [NSUM_W-1:0]       nsum;
   logic [PROD_W-1:0]       prod;
   logic signed [VAL_W-1:0] value;

   always_comb begin
      nsum = '0;
      for (int k = 0; k < NB_N; k++) begin
         nsum = nsum + NSUM_W'(s1_ff.nb[k]);
      end
      prod  = PROD_W'(s1_ff.ctr) * PROD_W'(s1_ff.coef);
      value = $signed({1'b0, prod}) - $signed({3'b000, nsum, 4'b0000});
   end

   always_comb begin
      out_free = !out_v_ff || rsp_bus.ready;
      take     = !s1_v_ff || out_free;
      s1_v_in  = s1_v_ff;
      if (load) begin
         s1_v_in = 1'b1;
      end else if (out_free) begin
         s1_v_in = 1'b0;
      end
      out_v_in = out_free ? s1_v_ff : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
      end
      if (load) begin
         s1_ff <= win;
      end
      if (out_free && s1_v_ff) begin
         out_value_ff <= value;
         out_last_ff  <= s1_ff.last;
      end
   end

   assign rsp_bus.valid = out_v_ff;
   assign rsp_bus.value = out_value_ff;
   assign rsp_bus.last  = out_last_ff;
endmodule

[src/laplacian_sharpen_3x3_top.sv]
// Top level of the streaming 3x3 Laplacian sharpening filter.
//
// Pixels of one channel arrive in raster order on req_bus (valid/ready); an
// item with flush set carries no pixel and drains the tail of the image once
// all pixels are in. Each result on rsp_bus is the unclipped signed kernel
// sum with 4 fractional bits, one row and one pixel behind the input, with
// last set on the final result of the image; counters then restart.
// Throughput: one item per cycle while neither the receiver nor a csr write
// or divider rebuild holds req_bus.ready low. The window lives in a chain of
// column cells fed by two line RAMs whose read for the next item is issued
// in the cycle the current one is accepted. A result reaches rsp_bus through
// the arithmetic stage register and then the output register. A stalled
// receiver holds the output register; one more result may wait in the
// arithmetic stage, after which req_bus.ready falls. Reset returns the
// registers to their defaults and clears the window and counters. After
// reset and after every csr write, ready stays low while the serial divider
// rebuilds the output row/column from the result count for the new width.
module laplacian_sharpen_3x3_top #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [lps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lps_pkg::CSR_DATA_W-1:0]   csr_wdata,
   lps_req_if.sink                          req_bus,
   lps_rsp_if.source                        rsp_bus
);
   import lps_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CNT_W = $clog2(MAX_WIDTH * IH_MAX + 1);

   // configuration
   logic              ftype_ff, ftype_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [IW_W-1:0]   width_ff, width_in;
   logic [IH_W-1:0]   height_ff, height_in;
   logic [IW_W-1:0]   w_eff;
   logic [IH_W-1:0]   h_eff;
   logic [TOT_W-1:0]  total_ff, total_in;

   // position state
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [COL_W-1:0]  ocol_ff, ocol_in;
   logic [ROW_W-1:0]  orow_ff, orow_in;
   logic              start_ff, start_in;

   // divider
   logic              div_busy, div_done;
   logic [CNT_W-1:0]  div_quo;
   logic [IW_W-1:0]   div_rem;

   // step control
   logic              busy, take, accept, step, clear, load;
   logic              pre_wrap, wrap, in_img, emit, last;
   logic              cc_first, cc_last, rc_first, rc_last;
   logic [COL_W-1:0]  cur_col, rd_addr;
   logic [ROW_W-1:0]  cur_row;
   logic [COL_W:0]    col_inc;
   logic [PIX_W-1:0]  pix, a_rd, b_rd;

   // window: link[c] is column c after the shift, link[KS-1] the new one
   lps_col_type       link [KS];
   logic [PIX_W-1:0]  pm [KS][KS];
   lps_win_type       win;

   // ---- configuration registers ----
   always_comb begin
      ftype_in  = ftype_ff;
      gain_in   = gain_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (lps_csr_type'(csr_index))
            CSR_FILTER_TYPE: ftype_in  = csr_wdata[0];
            CSR_GAIN:        gain_in   = csr_wdata[GAIN_W-1:0];
            CSR_WIDTH:       width_in  = csr_wdata[IW_W-1:0];
            CSR_HEIGHT:      height_in = csr_wdata[IH_W-1:0];
            default:         ftype_in  = ftype_ff;
         endcase
      end
   end

   always_comb begin
      if (width_ff < W_MIN) begin
         w_eff = W_MIN;
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = IW_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff    = (height_ff == '0) ? IH_W'(1) : height_ff;
      total_in = TOT_W'(w_eff) * TOT_W'(h_eff);
      start_in = csr_we;
   end

   // ---- input step ----
   always_comb begin
      busy          = start_ff || div_busy || div_done;
      req_bus.ready = !busy && !csr_we && take;
      accept        = req_bus.valid && req_bus.ready;

      // a column left past a narrowed width wraps before use
      pre_wrap = 32'(col_ff) >= 32'(w_eff);
      cur_col  = pre_wrap ? '0 : col_ff;
      cur_row  = pre_wrap ? row_ff + 1'b1 : row_ff;
      in_img   = 32'(cur_row) < 32'(h_eff);
      step     = accept && !(in_img && req_bus.flush);
      pix      = in_img ? req_bus.pixel : '0;
      emit     = (cur_row >= ROW_W'(2)) || (cur_row == ROW_W'(1) && cur_col != '0);
      col_inc  = {1'b0, cur_col} + 1'b1;
      wrap     = 32'(col_inc) >= 32'(w_eff);
      last     = (32'(cnt_ff) + 32'd1) >= 32'(total_ff);
      clear    = step && emit && last;
      load     = step && emit;

      // border flags of the output pixel
      cc_first = ocol_ff == '0;
      cc_last  = (32'(ocol_ff) + 32'd1) >= 32'(w_eff);
      rc_first = orow_ff == '0;
      rc_last  = (32'(orow_ff) + 32'd1) >= 32'(h_eff);
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      cnt_in  = cnt_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      if (accept && !step) begin
         // ignored flush still commits the wrap
         col_in = cur_col;
         row_in = cur_row;
      end
      if (step) begin
         if (clear) begin
            col_in  = '0;
            row_in  = '0;
            cnt_in  = '0;
            ocol_in = '0;
            orow_in = '0;
         end else begin
            col_in = wrap ? '0 : col_inc[COL_W-1:0];
            row_in = wrap ? cur_row + 1'b1 : cur_row;
            if (emit) begin
               cnt_in = cnt_ff + 1'b1;
               if (cc_last) begin
                  ocol_in = '0;
                  orow_in = (orow_ff == ROW_SAT) ? orow_ff : orow_ff + 1'b1;
               end else begin
                  ocol_in = ocol_ff + 1'b1;
               end
            end
         end
      end
      if (div_done) begin
         ocol_in = COL_W'(div_rem);
         orow_in = (32'(div_quo) > 32'(ROW_SAT)) ? ROW_SAT : ROW_W'(div_quo);
      end
      // next item's line read; while idle keep reading the current column
      rd_addr = accept ? col_in : cur_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ftype_ff  <= RST_TYPE;
         gain_ff   <= RST_GAIN;
         width_ff  <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
         col_ff    <= '0;
         row_ff    <= '0;
         cnt_ff    <= '0;
         ocol_ff   <= '0;
         orow_ff   <= '0;
         start_ff  <= 1'b1;
      end else begin
         ftype_ff  <= ftype_in;
         gain_ff   <= gain_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         cnt_ff    <= cnt_in;
         ocol_ff   <= ocol_in;
         orow_ff   <= orow_in;
         start_ff  <= start_in;
      end
      total_ff <= total_in;
   end

   // ---- line stores: a holds the older row, b the newer ----
   lps_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
      .clock (clock),
      .we    (step),
      .waddr (cur_col),
      .wdata (b_rd),
      .raddr (rd_addr),
      .rdata (a_rd)
   );

   lps_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
      .clock (clock),
      .we    (step),
      .waddr (cur_col),
      .wdata (pix),
      .raddr (rd_addr),
      .rdata (b_rd)
   );

   // ---- window cell chain ----
   always_comb begin
      link[KS-1][0] = a_rd;
      link[KS-1][1] = b_rd;
      link[KS-1][2] = pix;
   end

   for (genvar i = 0; i < KS - 1; i++) begin : g_cell
      lps_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (step),
         .clear   (clear),
         .nbr_col (link[i+1]),
         .own_col (link[i])
      );
   end

   // border and kernel-shape masking of the shifted window
   always_comb begin
      for (int c = 0; c < KS; c++) begin
         for (int r = 0; r < KS; r++) begin
            if ((c == 0 && cc_first) || (c == KS - 1 && cc_last) ||
                (r == 0 && rc_first) || (r == KS - 1 && rc_last) ||
                (ftype_ff == FT_FOUR && c != 1 && r != 1)) begin
               pm[c][r] = '0;
            end else begin
               pm[c][r] = link[c][r];
            end
         end
      end
      win.nb[0] = pm[0][0];
      win.nb[1] = pm[1][0];
      win.nb[2] = pm[2][0];
      win.nb[3] = pm[0][1];
      win.nb[4] = pm[2][1];
      win.nb[5] = pm[0][2];
      win.nb[6] = pm[1][2];
      win.nb[7] = pm[2][2];
      win.ctr   = pm[1][1];
      win.coef  = {1'b0, gain_ff} + ((ftype_ff == FT_EIGHT) ? CTR_EIGHT : CTR_FOUR);
      win.last  = last;
   end

   lps_kernel u_kernel (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .win     (win),
      .take    (take),
      .rsp_bus (rsp_bus)
   );

   // output position rebuilt as count / width after reset and every csr write
   lps_div #(.NUM_W(CNT_W), .DEN_W(IW_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .dividend  (cnt_ff),
      .divisor   (w_eff),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

`ifndef ASSERT_OFF
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |-> !start_ff && !div_busy && !div_done)
      else $error("item taken while output position is rebuilt");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      clear |=> col_ff == '0 && row_ff == '0 && cnt_ff == '0 &&
                ocol_ff == '0 && orow_ff == '0)
      else $error("counters not cleared after last result");

   a_ocol_range: assert property (@(posedge clock) disable iff (reset)
      accept |-> 32'(ocol_ff) < 32'(w_eff))
      else $error("output column beyond image width");
`endif
endmodule

[tb/sv/laplacian_sharpen_3x3_top_tb.sv]
// Self-checking testbench for the streaming 3x3 Laplacian sharpening filter.
module laplacian_sharpen_3x3_top_tb;
   import lps_pkg::*;

   localparam int LINE_DEPTH   = 1024;  // line store depth, matches MAX_WIDTH
   localparam int SETTLE       = 8;     // cycles after the last result before a csr write
   localparam int STALL_LIMIT  = 4000;  // cycles without any accepted item
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int PHASE_ITEMS  = 540;   // random items per idling phase
   localparam int REPORT_LIMIT = 200;   // keep the log short on a badly broken block

   // one filtered pixel as it should leave rsp_bus
   typedef struct {
      logic signed [VAL_W-1:0] value;
      logic                    last;
   } sharpened_t;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   lps_csr_type           csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lps_req_if req_bus ();
   lps_rsp_if rsp_bus ();

   laplacian_sharpen_3x3_top #(
      .MAX_WIDTH (LINE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   // ---------------------------------------------------------------------
   // Predictor state: a private copy of the registers, line stores, window
   // and position counters. Updated on every accepted item.
   // ---------------------------------------------------------------------
   logic              ftype;
   logic [GAIN_W-1:0] gain;
   logic [IW_W-1:0]   width_reg;
   logic [IH_W-1:0]   height_reg;
   logic [PIX_W-1:0]  older_row [LINE_DEPTH];  // two rows up
   logic [PIX_W-1:0]  newer_row [LINE_DEPTH];  // one row up
   logic [PIX_W-1:0]  win [3][3];              // [column][row], column 0 oldest
   int                col_in;
   int                row_in;
   int                results_done;

   sharpened_t expected_px [$];
   sharpened_t want;

   int fail_count;
   int items_sent;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;
   int stalled;

   // ---------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic int eff_width();
      if (width_reg < W_MIN) return int'(W_MIN);
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return int'(width_reg);
   endfunction

   function automatic int eff_height();
      return (height_reg == '0) ? 1 : int'(height_reg);
   endfunction

   function automatic void restart_image();
      foreach (win[c, r]) win[c][r] = '0;
      col_in       = 0;
      row_in       = 0;
      results_done = 0;
   endfunction

   // true while the next item still lands inside the image as a pixel
   function automatic bit pixels_pending();
      if (col_in >= eff_width()) return (row_in + 1) < eff_height();
      return row_in < eff_height();
   endfunction

   function automatic bit image_open();
      return col_in != 0 || row_in != 0 || results_done != 0;
   endfunction

   // Advance the model by one accepted item and queue the result it causes.
   function automatic void compute_sharpened(input logic [PIX_W-1:0] pix,
                                             input logic drain);
      int               w, h, rc, cc, centre, neigh, sum;
      int               p [3][3];
      logic [PIX_W-1:0] v;
      bit               emit;
      sharpened_t       res;
      w = eff_width();
      h = eff_height();
      if (col_in >= w) begin
         col_in = 0;
         row_in++;
      end
      // inside the image a flush is ignored; past it every item is a drain tick
      if (row_in < h) begin
         if (drain) return;
         v = pix;
      end else begin
         v = '0;
      end
      emit = (row_in >= 2) || (row_in == 1 && col_in >= 1);

      for (int c = 0; c < 2; c++)
         for (int r = 0; r < 3; r++)
            win[c][r] = win[c + 1][r];
      win[2][0] = older_row[col_in];
      win[2][1] = newer_row[col_in];
      win[2][2] = v;
      older_row[col_in] = newer_row[col_in];
      newer_row[col_in] = v;

      col_in++;
      if (col_in >= w) begin
         col_in = 0;
         row_in++;
      end
      if (!emit) return;

      // zero padding: mask window columns/rows outside the image
      rc = results_done / w;
      cc = results_done % w;
      foreach (p[c, r]) p[c][r] = int'(win[c][r]);
      if (cc == 0) for (int r = 0; r < 3; r++) p[0][r] = 0;
      if (cc + 1 >= w) for (int r = 0; r < 3; r++) p[2][r] = 0;
      if (rc == 0) for (int c = 0; c < 3; c++) p[c][0] = 0;
      if (rc + 1 >= h) for (int c = 0; c < 3; c++) p[c][2] = 0;

      neigh = p[1][0] + p[1][2] + p[0][1] + p[2][1];
      if (ftype == FT_EIGHT) begin
         neigh  += p[0][0] + p[2][0] + p[0][2] + p[2][2];
         centre  = int'(gain) + int'(CTR_EIGHT);
      end else begin
         centre  = int'(gain) + int'(CTR_FOUR);
      end
      sum = p[1][1] * centre - 16 * neigh;

      results_done++;
      res.value = VAL_W'(sum);
      res.last  = results_done >= w * h;
      expected_px.push_back(res);
      if (res.last) restart_image();
   endfunction

   // ---------------------------------------------------------------------
   // Driving: everything changes on the falling edge; tasks start and end
   // on a falling edge.
   // ---------------------------------------------------------------------
   task automatic send_item(input logic [PIX_W-1:0] pix, input logic drain);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel <= pix;
      req_bus.flush <= drain;
      do @(posedge clock); while (!req_bus.ready);
      compute_sharpened(pix, drain);
      items_sent++;
      @(negedge clock);
   endtask

   // mostly pixels while the image is filling, mostly flushes while draining;
   // the odd stray flush or stray pixel exercises the ignore/drain rules
   task automatic send_random_item();
      logic [PIX_W-1:0] pix;
      logic             drain;
      int               r;
      r = $urandom_range(99);
      if (r < 8)       pix = '0;
      else if (r < 16) pix = '1;
      else             pix = PIX_W'($urandom);
      if (pixels_pending()) drain = $urandom_range(99) < 5;
      else                  drain = $urandom_range(99) < 75;
      send_item(pix, drain);
   endtask

   // Lower valid, let every expected result arrive, then allow the pipeline
   // to settle (items with no result may still be in flight).
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_px.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input lps_csr_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FILTER_TYPE: ftype      = data[0];
         CSR_GAIN:        gain       = data[GAIN_W-1:0];
         CSR_WIDTH:       width_reg  = data[IW_W-1:0];
         CSR_HEIGHT:      height_reg = data[IH_W-1:0];
      endcase
      @(negedge clock);
   endtask

   // Run the current image to its last result; optionally pause the sender
   // after a number of items until the block has caught up.
   task automatic finish_image(input int pause_after);
      int n;
      bit opened;
      n      = 0;
      opened = 0;
      do begin
         send_random_item();
         n++;
         if (n == pause_after) wait_idle();
         if (image_open()) opened = 1;
      end while (!opened || image_open());
   endtask

   // small images most of the time, with out-of-range sizes and spare
   // upper data bits thrown in
   task automatic random_config();
      logic [IW_W-1:0]       w;
      logic [IH_W-1:0]       h;
      logic [CSR_DATA_W-1:0] g;
      int                    r;
      r = $urandom_range(99);
      if (r < 10)      w = IW_W'($urandom_range(2));
      else if (r < 90) w = IW_W'($urandom_range(12, 3));
      else             w = IW_W'($urandom_range(64, 13));
      h = ($urandom_range(99) < 10) ? '0 : IH_W'($urandom_range(6, 1));
      r = $urandom_range(99);
      if (r < 15)      g = {4'($urandom), 8'h00};
      else if (r < 30) g = {4'($urandom), 8'hFF};
      else             g = CSR_DATA_W'($urandom);
      write_reg(CSR_FILTER_TYPE, CSR_DATA_W'($urandom));
      write_reg(CSR_GAIN, g);
      write_reg(CSR_WIDTH, {1'($urandom_range(1)), w});
      write_reg(CSR_HEIGHT, h);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset defaults: 640 wide, four-neighbour, gain 1.0. One row plus a few
   // pixels gives the first results; then shrink the geometry so the image
   // wraps its column and ends early instead of needing 300k pixels.
   task automatic test_reset_defaults();
      for (int i = 0; i < int'(RST_WIDTH) + 5; i++) send_item(PIX_W'($urandom), 1'b0);
      wait_idle();
      write_reg(CSR_WIDTH, 12'd3);
      write_reg(CSR_HEIGHT, 12'd1);
      finish_image(0);
   endtask

   // Extremes of the output range, both kernels, clamped sizes, a flush
   // inside the image and a pixel after its end.
   task automatic test_directed_corners();
      wait_idle();
      write_reg(CSR_FILTER_TYPE, 12'h001);
      write_reg(CSR_GAIN, 12'h0FF);
      write_reg(CSR_WIDTH, 12'd3);
      write_reg(CSR_HEIGHT, 12'd3);
      // bright ring round a dark centre: most negative sum at the centre
      for (int i = 0; i < 9; i++) begin
         send_item((i == 4) ? 8'h00 : 8'hFF, 1'b0);
         if (i == 4) send_item(8'h33, 1'b1);   // flush mid-image, ignored
      end
      send_item(8'hA5, 1'b1);
      send_item(8'h5A, 1'b0);                  // pixel past the end drains
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b1);
      wait_idle();
      // width 0 clamps to 3, height 0 to 1; bright centre, dark sides: peak sum
      write_reg(CSR_WIDTH, 12'h000);
      write_reg(CSR_HEIGHT, 12'h000);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      repeat (4) send_item(8'h00, 1'b1);
      wait_idle();
      // four-neighbour kernel, no gain; upper data bits must be dropped
      write_reg(CSR_FILTER_TYPE, 12'hFFE);
      write_reg(CSR_GAIN, 12'hF00);
      write_reg(CSR_WIDTH, 12'd3);
      write_reg(CSR_HEIGHT, 12'd1);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      repeat (4) send_item(8'hFF, 1'b1);
   endtask

   // Widest row: width field all ones clamps to the line store depth.
   task automatic test_widest_row();
      wait_idle();
      write_reg(CSR_FILTER_TYPE, CSR_DATA_W'($urandom));
      write_reg(CSR_GAIN, CSR_DATA_W'($urandom));
      write_reg(CSR_WIDTH, 12'hFFF);
      write_reg(CSR_HEIGHT, 12'd1);
      finish_image(0);
   endtask

   // Geometry changed while an image is in progress: tallest height, then a
   // narrower width that forces a column wrap, then a height already passed
   // by the result count, which ends the image at the next result.
   task automatic test_live_reconfig();
      wait_idle();
      write_reg(CSR_FILTER_TYPE, 12'h001);
      write_reg(CSR_GAIN, CSR_DATA_W'($urandom));
      write_reg(CSR_WIDTH, 12'd10);
      write_reg(CSR_HEIGHT, 12'hFFF);
      for (int i = 0; i < 38; i++) send_item(PIX_W'($urandom), 1'b0);
      wait_idle();
      write_reg(CSR_WIDTH, 12'd6);
      for (int i = 0; i < 14; i++) send_item(PIX_W'($urandom), 1'b0);
      wait_idle();
      write_reg(CSR_HEIGHT, 12'd2);
      finish_image(0);
   endtask

   // Random images, half of them with a fresh setting. The first image may
   // carry a long receiver hold-off or a sender pause.
   task automatic test_random_images(input int n_items, input bit with_hold,
                                     input int pause_after);
      int  first_item;
      bit  first;
      first_item = items_sent;
      first      = 1;
      while (items_sent - first_item < n_items) begin
         if (first || $urandom_range(1)) begin
            wait_idle();
            random_config();
         end
         if (first && with_hold) hold_left = HOLD_CYCLES;
         finish_image(first ? pause_after : 0);
         first = 0;
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stalls, plus a hold-off counted down here
   // ---------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= $urandom_range(99) >= recv_stall_pct;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: every accepted item against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_px.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
               $display("%0t: unexpected result, value %0d last %0b",
                        $time, rsp_bus.value, rsp_bus.last);
            fail_count++;
         end else begin
            want = expected_px.pop_front();
            if (rsp_bus.value !== want.value) begin
               if (fail_count < REPORT_LIMIT)
                  $display("%0t: value mismatch, expected %0d, got %0d",
                           $time, want.value, rsp_bus.value);
               fail_count++;
            end
            if (rsp_bus.last !== want.last) begin
               if (fail_count < REPORT_LIMIT)
                  $display("%0t: last mismatch, expected %0b, got %0b",
                           $time, want.last, rsp_bus.last);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: ends the run if neither side moves an item for too long
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stalled <= 0;
      end else if (stalled >= STALL_LIMIT) begin
         $display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         stalled <= stalled + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_FILTER_TYPE;
      csr_wdata      = '0;
      req_bus.valid  = 1'b0;
      req_bus.pixel  = '0;
      req_bus.flush  = 1'b0;
      rsp_bus.ready  = 1'b0;
      fail_count     = 0;
      items_sent     = 0;
      hold_left      = 0;
      stalled        = 0;
      send_idle_pct  = 25;
      recv_stall_pct = 67;
      ftype          = RST_TYPE;
      gain           = RST_GAIN;
      width_reg      = RST_WIDTH;
      height_reg     = RST_HEIGHT;
      older_row      = '{default: '0};
      newer_row      = '{default: '0};
      restart_image();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender idles a quarter of the time, receiver two thirds
      test_reset_defaults();
      test_directed_corners();
      test_random_images(PHASE_ITEMS, 1'b1, 0);

      // the other way round
      send_idle_pct  = 67;
      recv_stall_pct = 25;
      test_live_reconfig();
      test_random_images(PHASE_ITEMS, 1'b0, 5);

      // full rate on both sides
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_widest_row();
      test_random_images(PHASE_ITEMS, 1'b0, 0);

      wait_idle();
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[files.f]
src/lps_pkg.sv
src/lps_if.sv
src/lps_ram.sv
src/lps_cell.sv
src/lps_div.sv
src/lps_kernel.sv
src/laplacian_sharpen_3x3_top.sv
tb/sv/laplacian_sharpen_3x3_top_tb.sv
